### src/lrutlb_pkg.sv
`timescale 1ns / 1ps

package lrutlb_pkg;

  localparam int unsigned CAP_W  = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 3;

  // byte address of the capacity register
  localparam logic [ADDR_W-1:0] CAP_ADDR = 3'd0;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  typedef struct packed {
    logic        func;
    logic [31:0] page_number;
    logic [31:0] frame_in;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] frame_out;
  } rsp_t;

  typedef struct packed {
    logic latch;
    logic match;
    logic select;
    logic promote;
    logic remove;
    logic evict;
    logic find;
    logic write;
    logic respond;
  } cmd_t;

  typedef struct packed {
    logic is_insert;
    logic any_match;
    logic evict_needed;
    logic out_free;
  } sts_t;

endpackage

### src/lrutlb_ctrl.sv
`timescale 1ns / 1ps

module lrutlb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lrutlb_pkg::sts_t  sts_i,
  output lrutlb_pkg::cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MATCH,
    ST_SELECT,
    ST_PROMOTE,
    ST_REM_OLD,
    ST_EVICT,
    ST_REM_VICTIM,
    ST_FIND,
    ST_WRITE,
    ST_RESPOND
  } state_e;

  state_e state_q;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    cmd_o         = '0;
    cmd_o.latch   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.match   = (state_q == ST_MATCH);
    cmd_o.select  = (state_q == ST_SELECT);
    cmd_o.promote = (state_q == ST_PROMOTE);
    cmd_o.remove  = (state_q == ST_REM_OLD) || (state_q == ST_REM_VICTIM);
    cmd_o.evict   = (state_q == ST_EVICT);
    cmd_o.find    = (state_q == ST_FIND);
    cmd_o.write   = (state_q == ST_WRITE);
    cmd_o.respond = (state_q == ST_RESPOND) && sts_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_MATCH;
        end
        ST_MATCH: state_q <= ST_SELECT;
        ST_SELECT: begin
          priority if (sts_i.is_insert && sts_i.any_match) state_q <= ST_REM_OLD;
          else if (sts_i.is_insert) state_q <= ST_EVICT;
          else if (sts_i.any_match) state_q <= ST_PROMOTE;
          else state_q <= ST_RESPOND;
        end
        ST_PROMOTE: state_q <= ST_RESPOND;
        ST_REM_OLD: state_q <= ST_EVICT;
        ST_EVICT: begin
          if (sts_i.evict_needed) state_q <= ST_REM_VICTIM;
          else state_q <= ST_FIND;
        end
        ST_REM_VICTIM: state_q <= ST_FIND;
        ST_FIND: state_q <= ST_WRITE;
        ST_WRITE: state_q <= ST_RESPOND;
        ST_RESPOND: begin
          if (sts_i.out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### src/lrutlb_dp.sv
`timescale 1ns / 1ps

module lrutlb_dp #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lrutlb_pkg::req_t               in_req_i,
  input  logic [lrutlb_pkg::CAP_W-1:0]   capacity_i,
  input  lrutlb_pkg::cmd_t               cmd_i,
  output lrutlb_pkg::sts_t               sts_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output lrutlb_pkg::rsp_t               out_rsp_o
);

  localparam int unsigned RW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  // control state
  logic [ENTRIES-1:0] valid_q;
  logic [RW-1:0]      rank_q [ENTRIES];
  logic [CW-1:0]      count_q;
  logic               out_valid_q;

  // payload
  logic [31:0]        page_q  [ENTRIES];
  logic [31:0]        frame_q [ENTRIES];
  lrutlb_pkg::req_t   item_q;
  logic [ENTRIES-1:0] mv_q;
  logic [ENTRIES-1:0] free_q;
  logic [RW-1:0]      sel_rank_q;
  logic [31:0]        sel_frame_q;
  logic               sel_hit_q;
  lrutlb_pkg::rsp_t   rsp_q;

  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] victim;
  logic [ENTRIES-1:0] free_vec;
  logic [ENTRIES-1:0] invalid;
  logic [RW-1:0]      sel_rank;
  logic [31:0]        sel_frame;
  logic [RW-1:0]      lru_rank;
  logic [CW-1:0]      cap_eff;
  logic               evict_needed;

  assign lru_rank = RW'(count_q - CW'(1));

  always_comb begin
    sel_rank  = '0;
    sel_frame = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = valid_q[i] && (page_q[i] == item_q.page_number);
      victim[i] = valid_q[i] && (rank_q[i] == lru_rank);
      if (mv_q[i]) begin
        sel_rank  = sel_rank | rank_q[i];
        sel_frame = sel_frame | frame_q[i];
      end
    end
  end

  // lowest free slot as a one-hot vector
  assign invalid  = ~valid_q;
  assign free_vec = invalid & (~invalid + ENTRIES'(1));

  // saturate capacity to the built depth, zero acts as one
  always_comb begin
    if (capacity_i == '0) begin
      cap_eff = CW'(1);
    end else if (32'(capacity_i) > 32'(ENTRIES)) begin
      cap_eff = CW'(ENTRIES);
    end else begin
      cap_eff = CW'(capacity_i);
    end
  end

  assign evict_needed = (count_q != '0) && (count_q >= cap_eff);

  always_comb begin
    sts_o              = '0;
    sts_o.is_insert    = (item_q.func == lrutlb_pkg::FUNC_INSERT);
    sts_o.any_match    = |mv_q;
    sts_o.evict_needed = evict_needed;
    sts_o.out_free     = !out_valid_q || !out_stall_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      if (cmd_i.respond) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (cmd_i.promote) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (mv_q[i]) begin
            rank_q[i] <= '0;
          end else if (valid_q[i] && (rank_q[i] < sel_rank_q)) begin
            rank_q[i] <= rank_q[i] + RW'(1);
          end
        end
      end

      if (cmd_i.remove) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (mv_q[i]) begin
            valid_q[i] <= 1'b0;
            rank_q[i]  <= '0;
          end else if (valid_q[i] && (rank_q[i] > sel_rank_q)) begin
            rank_q[i] <= rank_q[i] - RW'(1);
          end
        end
        count_q <= count_q - CW'(1);
      end

      if (cmd_i.write) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (free_q[i]) begin
            valid_q[i] <= 1'b1;
            rank_q[i]  <= '0;
          end else if (valid_q[i]) begin
            rank_q[i] <= rank_q[i] + RW'(1);
          end
        end
        count_q <= count_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= in_req_i;
    end
    if (cmd_i.match) begin
      mv_q <= match;
    end
    if (cmd_i.select) begin
      sel_rank_q  <= sel_rank;
      sel_frame_q <= sel_frame;
      sel_hit_q   <= |mv_q;
    end
    // victim is the valid entry holding the oldest rank
    if (cmd_i.evict) begin
      mv_q       <= victim;
      sel_rank_q <= lru_rank;
    end
    if (cmd_i.find) begin
      free_q <= free_vec;
    end
    if (cmd_i.write) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (free_q[i]) begin
          page_q[i]  <= item_q.page_number;
          frame_q[i] <= item_q.frame_in;
        end
      end
    end
    if (cmd_i.respond) begin
      rsp_q.hit       <= (item_q.func == lrutlb_pkg::FUNC_LOOKUP) && sel_hit_q;
      rsp_q.frame_out <= ((item_q.func == lrutlb_pkg::FUNC_LOOKUP) && sel_hit_q) ?
                         sel_frame_q : 32'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

### src/lru_tlb_unit.sv
`timescale 1ns / 1ps

// channel   direction  payload    handshake
// in        request    req_t      in_valid_i / in_stall_o
// out       response   rsp_t      out_valid_o / out_stall_i
// config    apb write  capacity   psel / penable / pwrite / pready
//
// one request at a time through a compare, select and update sequence:
// a lookup steps through match, select, promote on a hit, and respond; an insert through
// match, select, evict, find, write, respond (old copy or victim removal adds a step)
// the response sits in an output register, so the next request is taken while it waits
// reset invalidates all entries at once and sets capacity to 16

module lru_tlb_unit #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  lrutlb_pkg::req_t                in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output lrutlb_pkg::rsp_t                out_rsp_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lrutlb_pkg::ADDR_W-1:0]   paddr,
  input  logic [lrutlb_pkg::DATA_W-1:0]   pwdata,
  output logic [lrutlb_pkg::DATA_W-1:0]   prdata,
  output logic                            pready
);

  logic [lrutlb_pkg::CAP_W-1:0] capacity_q;
  logic                         cap_sel;
  lrutlb_pkg::cmd_t             cmd;
  lrutlb_pkg::sts_t             sts;

  // register index is the word address, low byte bits ignored
  assign cap_sel = (paddr[lrutlb_pkg::ADDR_W-1:2] == lrutlb_pkg::CAP_ADDR[lrutlb_pkg::ADDR_W-1:2]);
  assign pready  = 1'b1;
  assign prdata  = cap_sel ? lrutlb_pkg::DATA_W'(capacity_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= lrutlb_pkg::CAP_W'(16);
    end else if (psel && penable && pwrite && pready && cap_sel) begin
      capacity_q <= pwdata[lrutlb_pkg::CAP_W-1:0];
    end
  end

  lrutlb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lrutlb_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .capacity_i  (capacity_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
